### src/teb_pkg.sv
package teb_pkg;

    // field widths fixed by the interface
    localparam int RANGE_W    = 16;
    localparam int SPEED_W    = 16;
    localparam int ANGLE_W    = 16;
    localparam int STEP_W     = 12;
    localparam int TTC_W      = 24;
    localparam int COS_W      = 15;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // divider sizes: range shifted by ten over a 15-bit relative speed
    localparam int TTC_FRAC_W   = 10;
    localparam int DIVIDEND_W   = RANGE_W + TTC_FRAC_W;
    localparam int DIVISOR_W    = 15;
    localparam int PROD_W       = 32;

    localparam logic [TTC_W-1:0] TTC_MAX = {TTC_W{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP    = 2'd2;

    // register reset values
    localparam logic [TTC_W-1:0]   THRESHOLD_RST   = 24'd1536;
    localparam logic [ANGLE_W-1:0] START_ANGLE_RST = 16'hA000;
    localparam logic [STEP_W-1:0]  ANGLE_STEP_RST  = 12'd60;

    // parameter defaults
    localparam int MAX_BEAMS_DEF       = 2048;
    localparam int COS_TABLE_DEPTH_DEF = 1024;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [63:0] PI_Q29 = 64'd1686629713;

    typedef struct packed {
        logic                       op;
        logic [RANGE_W-1:0]         range_mm;
        logic signed [SPEED_W-1:0]  speed_mm_s;
        logic                       last;
    } in_t;

    typedef struct packed {
        logic               brake;
        logic [TTC_W-1:0]   min_ttc;
    } out_t;

    // beam word handed from the front to the back
    typedef struct packed {
        logic                       last;
        logic [RANGE_W-1:0]         range_mm;
        logic signed [SPEED_W-1:0]  speed;
        logic [ANGLE_W-1:0]         angle;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_MULT,
        ST_TEST,
        ST_DIVD,
        ST_DONE
    } back_state_t;

    // unsigned q0.15 cosine of u binary angle units (0..16384), taylor series in q2.29
    function automatic logic [COS_W-1:0] cos_quarter_q15(input logic [14:0] u);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] c;
        x    = ({49'd0, u} * PI_Q29) >> 15;
        x2   = (x * x) >> 29;
        term = 64'd1 << 29;
        sum  = 64'sd1 <<< 29;
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 29) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        c = (sum + 64'sd8192) >>> 14;
        if (c > 64'sd32767) begin
            c = 64'sd32767;
        end
        return c[COS_W-1:0];
    endfunction

endpackage

### src/teb_front.sv
module teb_front #(
    parameter int MAX_BEAMS = teb_pkg::MAX_BEAMS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  teb_pkg::in_t                  s_data,
    input  logic [teb_pkg::ANGLE_W-1:0]   start_angle,
    input  logic [teb_pkg::STEP_W-1:0]    angle_step,
    output logic                          push,
    output teb_pkg::cmd_t                 push_data,
    input  logic                          q_full
);

    localparam int IDX_W = $clog2(MAX_BEAMS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_BEAMS - 1);

    logic [IDX_W-1:0]                  idx_reg, idx_next;
    logic signed [teb_pkg::SPEED_W-1:0] speed_reg, speed_next;
    logic [IDX_W+teb_pkg::STEP_W-1:0]  offset;
    logic                              accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // beam angle from the running index
    assign offset = {{teb_pkg::STEP_W{1'b0}}, idx_reg} *
                    {{IDX_W{1'b0}}, angle_step};

    always_comb begin
        push_data.last     = s_data.last;
        push_data.range_mm = s_data.range_mm;
        push_data.speed    = speed_reg;
        push_data.angle    = start_angle + offset[teb_pkg::ANGLE_W-1:0];
        push               = accept && s_data.op;
    end

    // speed words stay here, beam words step the index and the last beam resets it
    always_comb begin
        idx_next   = idx_reg;
        speed_next = speed_reg;
        if (accept) begin
            if (!s_data.op) begin
                speed_next = s_data.speed_mm_s;
            end else if (s_data.last) begin
                idx_next = '0;
            end else if (idx_reg < IDX_LAST) begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            speed_reg <= '0;
        end else begin
            idx_reg   <= idx_next;
            speed_reg <= speed_next;
        end
    end

endmodule

### src/teb_fifo.sv
module teb_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  teb_pkg::cmd_t  push_data,
    input  logic           pop,
    output teb_pkg::cmd_t  pop_data,
    output logic           full,
    output logic           empty
);

    localparam int DEPTH = teb_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    teb_pkg::cmd_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/teb_div.sv
module teb_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [teb_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [teb_pkg::DIVISOR_W-1:0]     divisor,
    output logic                              done,
    output logic [teb_pkg::DIVIDEND_W-1:0]    quotient
);

    localparam int NW    = teb_pkg::DIVIDEND_W;
    localparam int DW    = teb_pkg::DIVISOR_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic [DW-1:0]    rem_reg, rem_next;
    logic [NW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DW:0]      trial;
    logic [DW:0]      diff;

    assign done     = done_reg;
    assign quotient = quo_reg;

    // one restoring step per cycle
    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DW]) begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

### src/teb_back.sv
module teb_back #(
    parameter int COS_TABLE_DEPTH = teb_pkg::COS_TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  teb_pkg::cmd_t                 q_data,
    input  logic                          q_empty,
    output logic                          pop,
    input  logic [teb_pkg::TTC_W-1:0]     brake_limit,
    output logic                          m_valid,
    input  logic                          m_ready,
    output teb_pkg::out_t                 m_data
);

    localparam int KW      = $clog2(COS_TABLE_DEPTH + 1);
    localparam int ENTRIES = COS_TABLE_DEPTH + 1;
    localparam int TW      = teb_pkg::TTC_W;

    typedef logic [teb_pkg::COS_W-1:0] rom_t [ENTRIES];

    // quarter-wave cosine table, filled at elaboration
    function automatic rom_t build_rom();
        rom_t        t;
        logic [31:0] u;
        for (int k = 0; k < ENTRIES; k++) begin
            u    = 32'((k * 16384) / COS_TABLE_DEPTH);
            t[k] = teb_pkg::cos_quarter_q15(u[14:0]);
        end
        return t;
    endfunction

    localparam rom_t COS_ROM = build_rom();

    teb_pkg::back_state_t             state_reg, state_next;
    teb_pkg::cmd_t                    cmd_reg, cmd_next;
    logic [KW-1:0]                    k_reg, k_next;
    logic                             neg_reg, neg_next;
    logic [teb_pkg::COS_W-1:0]        cos_reg;
    logic signed [teb_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [TW-1:0]                    min_reg, min_next;
    logic                             m_valid_reg, m_valid_next;
    teb_pkg::out_t                    m_data_reg, m_data_next;

    logic [1:0]                       quad;
    logic [14:0]                      off;
    logic [KW+14:0]                   kprod;
    logic signed [teb_pkg::SPEED_W-1:0] cos_s;
    logic                             div_start, div_done;
    logic [teb_pkg::DIVIDEND_W-1:0]   div_q;
    logic [TW-1:0]                    ttc;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // fold the angle into a quarter-wave table index
    assign quad  = q_data.angle[15:14];
    assign off   = quad[0] ? (15'd16384 - {1'b0, q_data.angle[13:0]})
                           : {1'b0, q_data.angle[13:0]};
    assign kprod = {{KW{1'b0}}, off} * (KW + 15)'(COS_TABLE_DEPTH);

    // signed cosine from the table word
    always_comb begin
        cos_s = {1'b0, cos_reg};
        if (neg_reg) begin
            cos_s = -cos_s;
        end
    end

    // saturate the quotient to the ttc width
    assign ttc = (|div_q[teb_pkg::DIVIDEND_W-1:TW]) ? teb_pkg::TTC_MAX : div_q[TW-1:0];

    teb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({cmd_reg.range_mm, {teb_pkg::TTC_FRAC_W{1'b0}}}),
        .divisor  (prod_reg[29:15]),
        .done     (div_done),
        .quotient (div_q)
    );

    // beam sequencer
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        k_next       = k_reg;
        neg_next     = neg_reg;
        prod_next    = prod_reg;
        min_next     = min_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        pop          = 1'b0;
        div_start    = 1'b0;
        unique case (state_reg)
            teb_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    pop        = 1'b1;
                    cmd_next   = q_data;
                    k_next     = kprod[KW+13:14];
                    neg_next   = quad[0] ^ quad[1];
                    state_next = teb_pkg::ST_LOOK;
                end
            end
            teb_pkg::ST_LOOK: begin
                state_next = teb_pkg::ST_MULT;
            end
            teb_pkg::ST_MULT: begin
                prod_next  = cmd_reg.speed * cos_s;
                state_next = teb_pkg::ST_TEST;
            end
            teb_pkg::ST_TEST: begin
                if (!prod_reg[teb_pkg::PROD_W-1] && (|prod_reg[30:15])) begin
                    div_start  = 1'b1;
                    state_next = teb_pkg::ST_DIVD;
                end else begin
                    state_next = teb_pkg::ST_DONE;
                end
            end
            teb_pkg::ST_DIVD: begin
                if (div_done) begin
                    if (ttc < min_reg) begin
                        min_next = ttc;
                    end
                    state_next = teb_pkg::ST_DONE;
                end
            end
            teb_pkg::ST_DONE: begin
                if (!cmd_reg.last) begin
                    state_next = teb_pkg::ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_data_next.brake   = (min_reg < brake_limit);
                    m_data_next.min_ttc = min_reg;
                    min_next            = teb_pkg::TTC_MAX;
                    state_next          = teb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = teb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= teb_pkg::ST_IDLE;
            min_reg     <= teb_pkg::TTC_MAX;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            min_reg     <= min_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers, registered table read
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        k_reg      <= k_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
        cos_reg    <= COS_ROM[k_reg];
    end

endmodule

### src/ttc_emergency_brake_unit.sv
// Time-to-collision emergency brake. Words on s_ are either speed updates
// (op 0), absorbed by the front end, or lidar beam ranges (op 1), which the
// front end tags with the beam angle and current speed and queues. The back
// end handles one beam at a time: table index, registered cosine lookup,
// speed-by-cosine multiply, then a serial divider for the ttc, which is
// skipped when the relative speed is not positive. The beam marked last
// emits one word on m_ with the scan's minimum ttc (1/1024 s, saturated)
// and brake = min_ttc < threshold. Write the cfg_ registers only while no
// scan is in flight.
module ttc_emergency_brake_unit #(
    parameter int MAX_BEAMS       = teb_pkg::MAX_BEAMS_DEF,
    parameter int COS_TABLE_DEPTH = teb_pkg::COS_TABLE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  teb_pkg::in_t                      s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output teb_pkg::out_t                     m_data,
    input  logic                              cfg_we,
    input  logic [teb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [teb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [teb_pkg::TTC_W-1:0]   threshold_reg, threshold_next;
    logic [teb_pkg::ANGLE_W-1:0] start_reg, start_next;
    logic [teb_pkg::STEP_W-1:0]  step_reg, step_next;

    logic           push, pop, q_full, q_empty;
    teb_pkg::cmd_t  push_data, q_data;

    // configuration decode
    always_comb begin
        threshold_next = threshold_reg;
        start_next     = start_reg;
        step_next      = step_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                teb_pkg::CFG_BRAKE_LIMIT:   threshold_next = cfg_data[teb_pkg::TTC_W-1:0];
                teb_pkg::CFG_START_ANGLE:   start_next     = cfg_data[teb_pkg::ANGLE_W-1:0];
                teb_pkg::CFG_ANGLE_STEP:    step_next      = cfg_data[teb_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= teb_pkg::THRESHOLD_RST;
            start_reg     <= teb_pkg::START_ANGLE_RST;
            step_reg      <= teb_pkg::ANGLE_STEP_RST;
        end else begin
            threshold_reg <= threshold_next;
            start_reg     <= start_next;
            step_reg      <= step_next;
        end
    end

    teb_front #(
        .MAX_BEAMS (MAX_BEAMS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .start_angle (start_reg),
        .angle_step  (step_reg),
        .push        (push),
        .push_data   (push_data),
        .q_full      (q_full)
    );

    teb_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    teb_back #(
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_data        (q_data),
        .q_empty       (q_empty),
        .pop           (pop),
        .brake_limit   (threshold_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

endmodule

### src/teb_checker.sv
module teb_checker (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_ready,
    input  logic           m_valid,
    input  logic           m_ready,
    input  teb_pkg::out_t  m_data
);

    // no result word survives reset
    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

    // queue is empty after reset so input is open
    a_reset_opens_in: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // brake needs a ttc below the saturated maximum
    a_brake_has_ttc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.brake |-> m_data.min_ttc != teb_pkg::TTC_MAX)
        else $error("brake with no computed ttc");

endmodule

bind ttc_emergency_brake_unit teb_checker u_teb_checker (.*);
